// ----- hdl/grc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the grid ray caster
// Holds the sequencer states, item and register codes, datapath widths and
// the fixed-point sine polynomial coefficients.
// ----------------------------------------------------------------------------
package grc_pkg;

    // Item codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_FOV    = 3'd0;
    localparam logic [2:0] CFG_STEP   = 3'd1;
    localparam logic [2:0] CFG_DEPTH  = 3'd2;
    localparam logic [2:0] CFG_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_HEIGHT = 3'd4;
    localparam logic [2:0] CFG_BCOS   = 3'd5;

    // Datapath widths, sized for the largest supported map
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIST_W  = 23;
    localparam int SQ_W    = 48;
    localparam int DIV_W   = 64;
    localparam int DEN_W   = 32;

    // Sine polynomial, Q30
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint COEF1   = 64'sd1686629713;
    localparam longint COEF3   = -64'sd693598668;
    localparam longint COEF5   = 64'sd85569306;
    localparam longint COEF7   = -64'sd5026995;
    localparam longint COEF9   = 64'sd172272;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ANG_MUL,
        S_ANG_DIVS,
        S_ANG_SUM,
        S_SIN_RD,
        S_COS_RD,
        S_EX_MUL,
        S_EY_MUL,
        S_MARCH_INIT,
        S_MARCH,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_SUM,
        S_FAR,
        S_TEST,
        S_SQRT,
        S_DOT_X,
        S_DOT_Y,
        S_DOT_SUM,
        S_COS_DIVS,
        S_CMP,
        S_NEXT,
        S_CEIL,
        S_CEIL_DIVS,
        S_CEIL_SAT,
        S_DONE,
        S_DIV
    } state_t;

endpackage
`default_nettype wire

// ----- hdl/grid_raycast_column_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_raycast_column_top: fixed-step ray caster for one screen column
// Loads a wall map row by row and casts one column ray per cast item,
// reporting ceiling and floor rows, a shade and the wall distance.
// ----------------------------------------------------------------------------
// A write item (action 0) stores one map row at the accepting edge and never
// raises busy. A cast item (action 1) raises busy and is answered by exactly
// one result, shown for a single cycle with done high; the receiver cannot
// stall, so it must take the result in that cycle. A cast starts with setup
// (the column-offset division, two sine table reads, two multiplies), then
// takes one march step per cycle up to the hit or the depth, and drains the
// map read pipeline. A wall hit adds the corner test: the squared distances
// of all four corners and, for each of up to three tested corners, a square
// root, a dot product and a division, plus control states. The ceiling row
// takes a multiply and another division. All of this runs on one multiplier,
// one radix-2 divider and one square root unit under the sequencer. At
// default settings the march loop dominates a ray that runs to full depth.
// ----------------------------------------------------------------------------
module grid_raycast_column_top
    import grc_pkg::*;
#(
    parameter int MAP_SIZE        = 16,
    parameter int SINE_TABLE_SIZE = 1024
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Item port
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               action,
    input  wire logic [3:0]         map_row_index,
    input  wire logic [15:0]        map_row_bits,
    input  wire logic [19:0]        player_x,
    input  wire logic [19:0]        player_y,
    input  wire logic [15:0]        player_angle,
    input  wire logic [9:0]         screen_column,
    // Result port
    output logic                    done,
    output logic [9:0]              result_column,
    output logic signed [9:0]       ceiling_row,
    output logic signed [10:0]      floor_row,
    output logic [1:0]              wall_shade,
    output logic                    on_boundary,
    output logic [20:0]             wall_distance,
    // Configuration port
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [30:0]        cfg_data
);

    localparam int CW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
    localparam int TW = $clog2(SINE_TABLE_SIZE);

    // ------------------------------------------------------------------
    // Sine table, built at elaboration by quadrant folding and a degree
    // nine odd polynomial; each entry is Q1.30.
    // ------------------------------------------------------------------
    typedef logic signed [31:0] sine_rom_t [SINE_TABLE_SIZE];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t tab;
        longint    q;
        longint    sq;
        longint    acc;
        int        quad;
        int        rem;
        for (int n = 0; n < SINE_TABLE_SIZE; n++) begin
            quad = (4 * n) / SINE_TABLE_SIZE;
            rem  = (4 * n) % SINE_TABLE_SIZE;
            q    = (longint'(rem) <<< 30) / SINE_TABLE_SIZE;
            if (quad[0]) begin
                q = Q30_ONE - q;
            end
            sq  = (q * q) / Q30_ONE;
            acc = COEF9;
            acc = COEF7 + (acc * sq) / Q30_ONE;
            acc = COEF5 + (acc * sq) / Q30_ONE;
            acc = COEF3 + (acc * sq) / Q30_ONE;
            acc = COEF1 + (acc * sq) / Q30_ONE;
            acc = (acc * q) / Q30_ONE;
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > Q30_ONE) begin
                acc = Q30_ONE;
            end
            tab[n] = quad[1] ? 32'(-acc) : 32'(acc);
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    function automatic logic [TW-1:0] sine_index(input logic [15:0] a);
        logic [28:0] prod;
        prod = 29'(a) * 29'(SINE_TABLE_SIZE);
        return prod[16 +: TW];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [15:0] fov_reg;
    logic [16:0] step_reg;
    logic [20:0] depth_reg;
    logic [9:0]  width_reg;
    logic [7:0]  height_reg;
    logic [30:0] bcos_reg;

    logic [MAP_SIZE-1:0] row_valid_reg;
    logic [MAP_SIZE-1:0] map_mem [MAP_SIZE];
    logic [MAP_SIZE-1:0] rd_row_reg;
    logic                rd_vld_reg;
    logic [CW-1:0]       rd_addr;

    logic signed [31:0]  rom_q_reg;
    logic [TW-1:0]       rom_addr;

    logic [19:0] px_reg, px_next;
    logic [19:0] py_reg, py_next;
    logic [15:0] pa_reg, pa_next;
    logic [9:0]  col_reg, col_next;
    logic [15:0] angle_reg, angle_next;
    logic signed [31:0] ex_reg, ex_next;
    logic signed [31:0] ey_reg, ey_next;
    logic signed [PROD_W-1:0] sx_reg, sx_next;
    logic signed [PROD_W-1:0] sy_reg, sy_next;
    logic signed [PROD_W-1:0] ax_reg, ax_next;
    logic signed [PROD_W-1:0] ay_reg, ay_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              front_on_reg, front_on_next;

    logic              st_valid_reg, st_valid_next;
    logic              st_out_reg, st_out_next;
    logic              st_last_reg, st_last_next;
    logic [7:0]        st_cx_reg, st_cx_next;
    logic [7:0]        st_cy_reg, st_cy_next;
    logic [DIST_W-1:0] st_dist_reg, st_dist_next;

    logic [7:0]        cx_reg, cx_next;
    logic [7:0]        cy_reg, cy_next;
    logic [DIST_W-1:0] fin_reg, fin_next;
    logic              edge_reg, edge_next;
    logic [1:0]        j_reg, j_next;
    logic [1:0]        far_reg, far_next;
    logic [SQ_W-1:0]   far_sq_reg, far_sq_next;
    logic [SQ_W-1:0]   sq_reg [4];
    logic [SQ_W-1:0]   sq_wdata;
    logic              sq_we;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic              neg_reg, neg_next;

    logic [63:0] rt_v_reg, rt_v_next;
    logic [63:0] rt_r_reg, rt_r_next;
    logic [63:0] rt_bit_reg, rt_bit_next;

    logic [DIV_W-1:0] dv_quo_reg, dv_quo_next;
    logic [DEN_W-1:0] dv_rem_reg, dv_rem_next;
    logic [DEN_W-1:0] dv_den_reg, dv_den_next;
    logic [5:0]       dv_cnt_reg, dv_cnt_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p_reg;

    logic signed [9:0]  ceil_reg, ceil_next;
    logic               done_next;
    logic [9:0]         res_col_next;
    logic signed [9:0]  res_ceil_next;
    logic signed [10:0] res_floor_next;
    logic [1:0]         res_shade_next;
    logic               res_edge_next;
    logic [20:0]        res_dist_next;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic               cast_accept;
    logic               write_accept;
    logic signed [24:0] fx_sum, fy_sum;
    logic signed [8:0]  fx_cell, fy_cell;
    logic               fx_out, fy_out;
    logic [16:0]        step_eff;
    logic signed [MUL_B_W-1:0] dx, dy;
    logic [23:0]        cx_pos, cy_pos;
    logic [32:0]        dv_trial;
    logic [63:0]        rt_sum;
    logic [PROD_W-1:0]  mag;
    logic [24:0]        d4, d3, dmax;

    assign busy         = (state_reg != S_IDLE);
    assign cast_accept  = start && !busy && (action == ACT_CAST);
    assign write_accept = start && !busy && (action == ACT_WRITE);
    assign step_eff     = (step_reg == 17'd0) ? 17'd1 : step_reg;

    // Ray point cells from the running products eye * distance.
    assign fx_sum  = $signed({5'b0, px_reg}) + 25'(ax_reg >>> 30);
    assign fy_sum  = $signed({5'b0, py_reg}) + 25'(ay_reg >>> 30);
    assign fx_cell = fx_sum[24:16];
    assign fy_cell = fy_sum[24:16];
    assign fx_out  = fx_cell[8] || (fx_cell[7:0] >= 8'(MAP_SIZE));
    assign fy_out  = fy_cell[8] || (fy_cell[7:0] >= 8'(MAP_SIZE));
    assign rd_addr = fx_cell[CW-1:0];

    // Corner offsets from the player for corner j of the hit cell.
    assign cx_pos = {(cx_reg + {7'b0, j_reg[1]}), 16'b0};
    assign cy_pos = {(cy_reg + {7'b0, j_reg[0]}), 16'b0};
    assign dx     = $signed(cx_pos) - $signed({4'b0, px_reg});
    assign dy     = $signed(cy_pos) - $signed({4'b0, py_reg});

    assign dv_trial = {dv_rem_reg, dv_quo_reg[DIV_W-1]};
    assign rt_sum   = rt_r_reg + rt_bit_reg;
    assign mag      = acc_reg[PROD_W-1] ? PROD_W'(-acc_reg) : PROD_W'(acc_reg);

    assign d4   = {fin_reg, 2'b0};
    assign d3   = 25'(fin_reg) + {1'b0, fin_reg, 1'b0};
    assign dmax = {4'b0, depth_reg};

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pa_next        = pa_reg;
        col_next       = col_reg;
        angle_next     = angle_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        dist_next      = dist_reg;
        front_on_next  = front_on_reg;
        st_valid_next  = 1'b0;
        st_out_next    = st_out_reg;
        st_last_next   = st_last_reg;
        st_cx_next     = st_cx_reg;
        st_cy_next     = st_cy_reg;
        st_dist_next   = st_dist_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        fin_next       = fin_reg;
        edge_next      = edge_reg;
        j_next         = j_reg;
        far_next       = far_reg;
        far_sq_next    = far_sq_reg;
        sq_we          = 1'b0;
        sq_wdata       = SQ_W'(acc_reg + mul_p_reg);
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        rt_v_next      = rt_v_reg;
        rt_r_next      = rt_r_reg;
        rt_bit_next    = rt_bit_reg;
        dv_quo_next    = dv_quo_reg;
        dv_rem_next    = dv_rem_reg;
        dv_den_next    = dv_den_reg;
        dv_cnt_next    = dv_cnt_reg;
        mul_a          = '0;
        mul_b          = '0;
        rom_addr       = sine_index(angle_reg);
        ceil_next      = ceil_reg;
        done_next      = 1'b0;
        res_col_next   = col_reg;
        res_ceil_next  = ceil_reg;
        res_floor_next = $signed({3'b0, height_reg}) - $signed({ceil_reg[9], ceil_reg});
        res_shade_next = 2'd0;
        res_edge_next  = edge_reg;
        res_dist_next  = (fin_reg > DIST_W'(21'h1FFFFF)) ? 21'h1FFFFF : fin_reg[20:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cast_accept)
                begin
                    px_next    = player_x;
                    py_next    = player_y;
                    pa_next    = player_angle;
                    col_next   = screen_column;
                    state_next = S_ANG_MUL;
                end
            end
            S_ANG_MUL:
            begin
                edge_next  = 1'b0;
                mul_a      = MUL_A_W'({16'b0, fov_reg});
                mul_b      = MUL_B_W'({14'b0, col_reg});
                state_next = S_ANG_DIVS;
            end
            S_ANG_DIVS:
            begin
                if (width_reg == 10'd0)
                begin
                    dv_quo_next = '0;
                    state_next  = S_ANG_SUM;
                end
                else
                begin
                    dv_quo_next = DIV_W'(unsigned'(mul_p_reg));
                    dv_rem_next = '0;
                    dv_den_next = DEN_W'(width_reg);
                    dv_cnt_next = '0;
                    ret_next    = S_ANG_SUM;
                    state_next  = S_DIV;
                end
            end
            S_ANG_SUM:
            begin
                angle_next = pa_reg - {1'b0, fov_reg[15:1]} + dv_quo_reg[15:0];
                state_next = S_SIN_RD;
            end
            S_SIN_RD:
            begin
                rom_addr   = sine_index(angle_reg);
                state_next = S_COS_RD;
            end
            S_COS_RD:
            begin
                rom_addr   = sine_index(angle_reg + 16'd16384);
                ex_next    = rom_q_reg;
                state_next = S_EX_MUL;
            end
            S_EX_MUL:
            begin
                ey_next    = rom_q_reg;
                mul_a      = ex_reg;
                mul_b      = MUL_B_W'({7'b0, step_eff});
                state_next = S_EY_MUL;
            end
            S_EY_MUL:
            begin
                sx_next    = mul_p_reg;
                mul_a      = ey_reg;
                mul_b      = MUL_B_W'({7'b0, step_eff});
                state_next = S_MARCH_INIT;
            end
            S_MARCH_INIT:
            begin
                sy_next       = mul_p_reg;
                ax_next       = sx_reg;
                ay_next       = mul_p_reg;
                dist_next     = DIST_W'(step_eff);
                front_on_next = 1'b1;
                if (depth_reg == 21'd0)
                begin
                    fin_next   = '0;
                    state_next = S_CEIL;
                end
                else
                begin
                    state_next = S_MARCH;
                end
            end
            S_MARCH:
            begin
                // Front: take the next ray point and start its map read.
                if (front_on_reg)
                begin
                    st_valid_next = 1'b1;
                    st_out_next   = fx_out || fy_out;
                    st_last_next  = (dist_reg >= DIST_W'(depth_reg));
                    st_cx_next    = fx_cell[7:0];
                    st_cy_next    = fy_cell[7:0];
                    st_dist_next  = dist_reg;
                    ax_next       = ax_reg + sx_reg;
                    ay_next       = ay_reg + sy_reg;
                    dist_next     = dist_reg + DIST_W'(step_eff);
                    if (dist_reg >= DIST_W'(depth_reg))
                    begin
                        front_on_next = 1'b0;
                    end
                end
                // Back: judge the point whose row has been read.
                if (st_valid_reg)
                begin
                    if (st_out_reg)
                    begin
                        fin_next   = DIST_W'(depth_reg);
                        state_next = S_CEIL;
                    end
                    else if (rd_vld_reg && rd_row_reg[st_cy_reg[CW-1:0]])
                    begin
                        cx_next     = st_cx_reg;
                        cy_next     = st_cy_reg;
                        fin_next    = st_dist_reg;
                        j_next      = 2'd0;
                        far_next    = 2'd0;
                        far_sq_next = '0;
                        state_next  = S_SQ_X;
                    end
                    else if (st_last_reg)
                    begin
                        fin_next   = DIST_W'(depth_reg);
                        state_next = S_CEIL;
                    end
                end
            end
            S_SQ_X:
            begin
                mul_a      = MUL_A_W'(dx);
                mul_b      = dx;
                state_next = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                acc_next   = mul_p_reg;
                mul_a      = MUL_A_W'(dy);
                mul_b      = dy;
                state_next = S_SQ_SUM;
            end
            S_SQ_SUM:
            begin
                sq_we      = 1'b1;
                acc_next   = acc_reg + mul_p_reg;
                state_next = S_FAR;
            end
            S_FAR:
            begin
                // Ties move the farthest corner to the later one.
                if (SQ_W'(acc_reg) >= far_sq_reg)
                begin
                    far_next    = j_reg;
                    far_sq_next = SQ_W'(acc_reg);
                end
                if (j_reg == 2'd3)
                begin
                    j_next     = 2'd0;
                    state_next = S_TEST;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_SQ_X;
                end
            end
            S_TEST:
            begin
                // The farthest corner and a corner under the player are skipped.
                if ((j_reg == far_reg) || (sq_reg[j_reg] == '0))
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    rt_v_next   = {sq_reg[j_reg], 16'b0};
                    rt_r_next   = '0;
                    rt_bit_next = 64'h4000_0000_0000_0000;
                    state_next  = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (rt_v_reg >= rt_sum)
                begin
                    rt_v_next = rt_v_reg - rt_sum;
                    rt_r_next = (rt_r_reg >> 1) + rt_bit_reg;
                end
                else
                begin
                    rt_r_next = rt_r_reg >> 1;
                end
                rt_bit_next = rt_bit_reg >> 2;
                if (rt_bit_reg[0])
                begin
                    state_next = S_DOT_X;
                end
            end
            S_DOT_X:
            begin
                mul_a      = ex_reg;
                mul_b      = dx;
                state_next = S_DOT_Y;
            end
            S_DOT_Y:
            begin
                acc_next   = mul_p_reg;
                mul_a      = ey_reg;
                mul_b      = dy;
                state_next = S_DOT_SUM;
            end
            S_DOT_SUM:
            begin
                acc_next   = acc_reg + mul_p_reg;
                state_next = S_COS_DIVS;
            end
            S_COS_DIVS:
            begin
                neg_next    = acc_reg[PROD_W-1];
                dv_quo_next = DIV_W'(mag) << 8;
                dv_rem_next = '0;
                dv_den_next = rt_r_reg[DEN_W-1:0];
                dv_cnt_next = '0;
                ret_next    = S_CMP;
                state_next  = S_DIV;
            end
            S_CMP:
            begin
                if (!neg_reg && (dv_quo_reg > DIV_W'(bcos_reg)))
                begin
                    edge_next = 1'b1;
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (j_reg == 2'd3)
                begin
                    state_next = S_CEIL;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_TEST;
                end
            end
            S_CEIL:
            begin
                if (fin_reg == '0)
                begin
                    ceil_next  = -10'sd256;
                    state_next = S_DONE;
                end
                else
                begin
                    mul_a      = $signed({9'b0, fin_reg}) - 32'sd131072;
                    mul_b      = MUL_B_W'({16'b0, height_reg});
                    state_next = S_CEIL_DIVS;
                end
            end
            S_CEIL_DIVS:
            begin
                neg_next    = mul_p_reg[PROD_W-1];
                dv_quo_next = mul_p_reg[PROD_W-1] ? DIV_W'(PROD_W'(-mul_p_reg))
                                                  : DIV_W'(PROD_W'(mul_p_reg));
                dv_rem_next = '0;
                dv_den_next = DEN_W'({fin_reg, 1'b0});
                dv_cnt_next = '0;
                ret_next    = S_CEIL_SAT;
                state_next  = S_DIV;
            end
            S_CEIL_SAT:
            begin
                if (dv_quo_reg > DIV_W'(256))
                begin
                    ceil_next = neg_reg ? -10'sd256 : 10'sd256;
                end
                else
                begin
                    ceil_next = neg_reg ? -$signed(dv_quo_reg[9:0]) : $signed(dv_quo_reg[9:0]);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                if (edge_reg)
                begin
                    res_shade_next = 2'd0;
                end
                else if (d4 <= dmax)
                begin
                    res_shade_next = 2'd3;
                end
                else if (d3 < dmax)
                begin
                    res_shade_next = 2'd2;
                end
                else if (25'(fin_reg) < dmax)
                begin
                    res_shade_next = 2'd1;
                end
                else
                begin
                    res_shade_next = 2'd0;
                end
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (dv_trial >= {1'b0, dv_den_reg})
                begin
                    dv_rem_next = DEN_W'(dv_trial - {1'b0, dv_den_reg});
                    dv_quo_next = {dv_quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next = dv_trial[DEN_W-1:0];
                    dv_quo_next = {dv_quo_reg[DIV_W-2:0], 1'b0};
                end
                dv_cnt_next = dv_cnt_reg + 6'd1;
                if (dv_cnt_reg == 6'd63)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_on_reg  <= 1'b0;
            st_valid_reg  <= 1'b0;
            done          <= 1'b0;
            row_valid_reg <= '0;
            fov_reg       <= 16'd8192;
            step_reg      <= 17'd66;
            depth_reg     <= 21'd1048576;
            width_reg     <= 10'd454;
            height_reg    <= 8'd106;
            bcos_reg      <= 31'd1073728402;
        end
        else
        begin
            state_reg    <= state_next;
            front_on_reg <= front_on_next;
            st_valid_reg <= st_valid_next;
            done         <= done_next;
            if (write_accept && (7'(map_row_index) < 7'(MAP_SIZE)))
            begin
                row_valid_reg[CW'(map_row_index)] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FOV:    fov_reg    <= cfg_data[15:0];
                    CFG_STEP:   step_reg   <= cfg_data[16:0];
                    CFG_DEPTH:  depth_reg  <= cfg_data[20:0];
                    CFG_WIDTH:  width_reg  <= cfg_data[9:0];
                    CFG_HEIGHT: height_reg <= cfg_data[7:0];
                    CFG_BCOS:   bcos_reg   <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Map memory and sine table, registered reads
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (write_accept && (7'(map_row_index) < 7'(MAP_SIZE)))
        begin
            map_mem[CW'(map_row_index)] <= MAP_SIZE'(map_row_bits);
        end
        rd_row_reg <= map_mem[rd_addr];
        rd_vld_reg <= row_valid_reg[rd_addr];
        rom_q_reg  <= SINE_ROM[rom_addr];
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        ret_reg     <= ret_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pa_reg      <= pa_next;
        col_reg     <= col_next;
        angle_reg   <= angle_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        dist_reg    <= dist_next;
        st_out_reg  <= st_out_next;
        st_last_reg <= st_last_next;
        st_cx_reg   <= st_cx_next;
        st_cy_reg   <= st_cy_next;
        st_dist_reg <= st_dist_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        fin_reg     <= fin_next;
        edge_reg    <= edge_next;
        j_reg       <= j_next;
        far_reg     <= far_next;
        far_sq_reg  <= far_sq_next;
        if (sq_we)
        begin
            sq_reg[j_reg] <= sq_wdata;
        end
        acc_reg     <= acc_next;
        neg_reg     <= neg_next;
        rt_v_reg    <= rt_v_next;
        rt_r_reg    <= rt_r_next;
        rt_bit_reg  <= rt_bit_next;
        dv_quo_reg  <= dv_quo_next;
        dv_rem_reg  <= dv_rem_next;
        dv_den_reg  <= dv_den_next;
        dv_cnt_reg  <= dv_cnt_next;
        mul_p_reg   <= mul_a * mul_b;
        ceil_reg    <= ceil_next;
        if (done_next)
        begin
            result_column <= res_col_next;
            ceiling_row   <= res_ceil_next;
            floor_row     <= res_floor_next;
            wall_shade    <= res_shade_next;
            on_boundary   <= res_edge_next;
            wall_distance <= res_dist_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cast_accept |=> busy)
        else $error("cast item accepted but block not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while sequencer still busy");

    a_edge_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (done && on_boundary) |-> (wall_shade == 2'd0))
        else $error("shade not blanked on a tile boundary");

    a_ceil_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((ceiling_row >= -10'sd256) && (ceiling_row <= 10'sd256)))
        else $error("ceiling row outside saturation range");

    a_march_state: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid_reg |-> $past(state_reg == S_MARCH))
        else $error("march stage valid outside the march loop");
`endif

endmodule
`default_nettype wire
